>>> hw/rtl/deque_with_delete_by_value_assert.svh
// assertion macros for the deque block
// expects clk_i and rst_ni in the including module's scope
`ifndef DEQUE_WITH_DELETE_BY_VALUE_ASSERT_SVH
`define DEQUE_WITH_DELETE_BY_VALUE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define DEQ_ASSERT_HOLDS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("deque check failed");

// consequent holds in the same cycle
`define DEQ_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deque check failed");

// consequent holds in the next cycle
`define DEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

>>> hw/rtl/deq_pkg.sv
// shared types and constants for the deque with delete by value
// no dependencies
package deq_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned IN_W   = 40;
  localparam int unsigned OUT_W  = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_BACK  = 3'd0,
    CMD_INS_FRONT = 3'd1,
    CMD_REM_FRONT = 3'd2,
    CMD_REM_BACK  = 3'd3,
    CMD_REM_VAL   = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } stat_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } st_e;

endpackage

>>> hw/rtl/deq_mem.sv
// entry store: one write port and one read port with registered read data
// depends on deq_pkg
module deq_mem import deq_pkg::*; #(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [VAL_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [VAL_W-1:0] rdata_o
);

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/deq_slot.sv
// shared slot unit: front position plus offset, wrapped at the capacity
// no package dependencies
module deq_slot #(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  logic [AW-1:0] base_i,
  input  logic [AW-1:0] off_i,
  output logic [AW-1:0] slot_o
);

  localparam logic [AW:0] CAP_S = (AW+1)'(CAPACITY);

  logic [AW:0] sum;
  logic [AW:0] wrapped;

  always_comb begin
    sum = {1'b0, base_i} + {1'b0, off_i};
    if (sum >= CAP_S) begin
      wrapped = sum - CAP_S;
    end else begin
      wrapped = sum;
    end
  end

  assign slot_o = wrapped[AW-1:0];

endmodule

>>> hw/rtl/deque_with_delete_by_value.sv
// top level of the deque with delete by value: sequencer, state and output register
// depends on deq_pkg, deq_mem, deq_slot and deque_with_delete_by_value_assert.svh
//
//   channel   dir  tdata fields (low bit up)
//   s_axis    in   command[2:0], value[34:3], zero fill
//   m_axis    out  status[1:0], removed_value[33:2], entry_count[38:34], zero fill
//
// inserts pass through exec and done; remove front/back pass through exec, rdwait and done
// remove by value passes through exec, scans and, when found, closes up the gap before done
// scan and close-up go one entry per cycle through the single store read port
// s_axis_tready is high only in idle; a waiting result does not block the next beat
// reset empties the list; the entry store itself is not cleared
module deque_with_delete_by_value import deq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // command, value
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata   // status, removed_value, entry_count
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C  = CW'(1);
  localparam logic [AW-1:0] LAST_C = AW'(CAPACITY - 1);
  localparam logic [AW-1:0] ZERO_A = '0;

  st_e              state_q, state_d;
  cmd_e             cmd_q, cmd_d;
  logic [VAL_W-1:0] value_q, value_d;
  stat_e            status_q, status_d;
  logic [VAL_W-1:0] removed_q, removed_d;
  logic [AW-1:0]    front_q, front_d;
  logic [CW-1:0]    occ_q, occ_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    rslot_q, rslot_d;
  logic [AW-1:0]    hole_q, hole_d;
  logic             m_valid_q, m_valid_d;
  stat_e            out_status_q, out_status_d;
  logic [VAL_W-1:0] out_removed_q, out_removed_d;
  logic [CNT_W-1:0] out_count_q, out_count_d;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [VAL_W-1:0] mem_wdata, mem_rdata;
  logic [AW-1:0]    slot_off, slot;
  logic [CW+CNT_W-1:0] occ_ext;

  logic in_beat, out_free, is_full, is_empty, more, found;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign is_full  = (occ_q >= CAP_C);
  assign is_empty = (occ_q == '0);
  assign more     = (idx_q < occ_q);
  assign found    = (mem_rdata == value_q);
  assign occ_ext  = {{CNT_W{1'b0}}, occ_d};

  deq_slot #(.CAPACITY(CAPACITY)) u_slot (
    .base_i (front_q),
    .off_i  (slot_off),
    .slot_o (slot)
  );

  deq_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cmd_q)
          CMD_REM_FRONT, CMD_REM_BACK: state_d = is_empty ? ST_DONE : ST_RDWAIT;
          CMD_REM_VAL:                 state_d = is_empty ? ST_DONE : ST_SCAN;
          default:                     state_d = ST_DONE;
        endcase
      end
      ST_RDWAIT: state_d = ST_DONE;
      ST_SCAN: begin
        if (found) begin
          state_d = more ? ST_SHIFT : ST_DONE;
        end else begin
          state_d = more ? ST_SCAN : ST_DONE;
        end
      end
      ST_SHIFT: state_d = more ? ST_SHIFT : ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    cmd_d         = cmd_q;
    value_d       = value_q;
    status_d      = status_q;
    removed_d     = removed_q;
    front_d       = front_q;
    occ_d         = occ_q;
    idx_d         = idx_q;
    rslot_d       = rslot_q;
    hole_d        = hole_q;
    m_valid_d     = m_valid_q && !m_axis_tready;
    out_status_d  = out_status_q;
    out_removed_d = out_removed_q;
    out_count_d   = out_count_q;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = slot;
    mem_raddr     = slot;
    mem_wdata     = value_q;
    slot_off      = idx_q[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          cmd_d     = cmd_e'(s_axis_tdata[CMD_W-1:0]);
          value_d   = s_axis_tdata[CMD_W+VAL_W-1:CMD_W];
          status_d  = STAT_OK;
          removed_d = '0;
        end
      end
      ST_EXEC: begin
        case (cmd_q)
          CMD_INS_BACK: begin
            if (is_full) begin
              status_d = STAT_FULL;
            end else begin
              slot_off = occ_q[AW-1:0];
              mem_we   = 1'b1;
              occ_d    = occ_q + ONE_C;
            end
          end
          CMD_INS_FRONT: begin
            if (is_full) begin
              status_d = STAT_FULL;
            end else begin
              front_d   = (front_q == ZERO_A) ? LAST_C : front_q - AW'(1);
              mem_waddr = front_d;
              mem_we    = 1'b1;
              occ_d     = occ_q + ONE_C;
            end
          end
          CMD_REM_FRONT, CMD_REM_VAL: begin
            if (is_empty) begin
              status_d = STAT_EMPTY;
            end else begin
              slot_off = ZERO_A;
              mem_re   = 1'b1;
              rslot_d  = slot;
              idx_d    = ONE_C;
            end
          end
          CMD_REM_BACK: begin
            if (is_empty) begin
              status_d = STAT_EMPTY;
            end else begin
              slot_off = AW'(occ_q - ONE_C);
              mem_re   = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_RDWAIT: begin
        removed_d = mem_rdata;
        occ_d     = occ_q - ONE_C;
        if (cmd_q == CMD_REM_FRONT) begin
          front_d = (front_q == LAST_C) ? ZERO_A : front_q + AW'(1);
        end
      end
      ST_SCAN: begin
        if (more) begin
          mem_re  = 1'b1;
          rslot_d = slot;
          idx_d   = idx_q + ONE_C;
        end
        if (found) begin
          removed_d = mem_rdata;
          hole_d    = rslot_q;
          if (!more) begin
            occ_d = occ_q - ONE_C;
          end
        end else if (!more) begin
          status_d = STAT_NOT_FOUND;
        end
      end
      ST_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = hole_q;
        mem_wdata = mem_rdata;
        hole_d    = rslot_q;
        if (more) begin
          mem_re  = 1'b1;
          rslot_d = slot;
          idx_d   = idx_q + ONE_C;
        end else begin
          occ_d = occ_q - ONE_C;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d     = 1'b1;
          out_status_d  = status_q;
          out_removed_d = removed_q;
          out_count_d   = occ_ext[CNT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      front_q   <= '0;
      occ_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      occ_q     <= occ_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    value_q       <= value_d;
    status_q      <= status_d;
    removed_q     <= removed_d;
    idx_q         <= idx_d;
    rslot_q       <= rslot_d;
    hole_q        <= hole_d;
    out_status_q  <= out_status_d;
    out_removed_q <= out_removed_d;
    out_count_q   <= out_count_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, out_count_q, out_removed_q, out_status_q};

`include "deque_with_delete_by_value_assert.svh"

  `DEQ_ASSERT_HOLDS(a_occ_bound, occ_q <= CAP_C)
  `DEQ_ASSERT_HOLDS(a_front_bound, front_q <= LAST_C)
  `DEQ_ASSERT_IMPLIES(a_no_port_clash, mem_we && mem_re, mem_waddr != mem_raddr)
  `DEQ_ASSERT_NEXT(a_full_keeps, (state_q == ST_EXEC) && is_full && ((cmd_q == CMD_INS_BACK) || (cmd_q == CMD_INS_FRONT)), occ_q == CAP_C)
  `DEQ_ASSERT_NEXT(a_result_loaded, (state_q == ST_DONE) && out_free, m_valid_q && (state_q == ST_IDLE))

endmodule
